FILE: hdl/rcta_pkg.sv
package rcta_pkg;

  localparam int Q_BITS = 17;
  localparam logic [Q_BITS-1:0] WEIGHT_ONE = 17'h10000;

  typedef enum logic [1:0] {
    SURF_SKY   = 2'd0,
    SURF_WALL  = 2'd1,
    SURF_FLOOR = 2'd2
  } surface_t;

  typedef struct packed {
    logic [23:0] viewer_y;
    logic [23:0] viewer_x;
    logic [23:0] floor_hit_y;
    logic [23:0] floor_hit_x;
    logic [23:0] wall_distance;
    logic [5:0]  wall_texel_col;
    logic [15:0] slice_height;
    logic [9:0]  span_end;
    logic [8:0]  span_start;
    logic [8:0]  row;
  } pixel_t;

  typedef struct packed {
    surface_t    surface;
    logic [5:0]  wall_u;
    logic        wall_neg;
    logic        wall_sat;
    logic        floor_one;
    logic [23:0] floor_hit_x;
    logic [23:0] floor_hit_y;
    logic [23:0] viewer_x;
    logic [23:0] viewer_y;
  } side_t;

endpackage

FILE: hdl/rcta_cell.sv
module rcta_cell #(
  parameter int WN_W   = 35,
  parameter int WD_W   = 24,
  parameter int FN_W   = 42,
  parameter int FD_W   = 34,
  parameter int SHIFT  = 0,
  parameter int Q_W    = 17,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [WN_W-1:0]   in_wrem,
  input  logic [WD_W-1:0]   in_wden,
  input  logic [Q_W-1:0]    in_wq,
  input  logic [FN_W-1:0]   in_frem,
  input  logic [FD_W-1:0]   in_fden,
  input  logic [Q_W-1:0]    in_fq,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [WN_W-1:0]   out_wrem,
  output logic [WD_W-1:0]   out_wden,
  output logic [Q_W-1:0]    out_wq,
  output logic [FN_W-1:0]   out_frem,
  output logic [FD_W-1:0]   out_fden,
  output logic [Q_W-1:0]    out_fq,
  output logic [SIDE_W-1:0] out_side
);

  localparam int WCW = ((WN_W > WD_W + SHIFT) ? WN_W : WD_W + SHIFT) + 1;
  localparam int FCW = ((FN_W > FD_W + SHIFT) ? FN_W : FD_W + SHIFT) + 1;

  logic [WCW-1:0] wrem_x, wden_x, wdiff;
  logic [FCW-1:0] frem_x, fden_x, fdiff;
  logic           wge, fge;

  always_comb begin
    wrem_x = WCW'(in_wrem);
    wden_x = WCW'(in_wden) << SHIFT;
    wge    = wrem_x >= wden_x;
    wdiff  = wrem_x - wden_x;
    frem_x = FCW'(in_frem);
    fden_x = FCW'(in_fden) << SHIFT;
    fge    = frem_x >= fden_x;
    fdiff  = frem_x - fden_x;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_wrem <= wge ? wdiff[WN_W-1:0] : in_wrem;
      out_wden <= in_wden;
      out_wq   <= {in_wq[Q_W-2:0], wge};
      out_frem <= fge ? fdiff[FN_W-1:0] : in_frem;
      out_fden <= in_fden;
      out_fq   <= {in_fq[Q_W-2:0], fge};
      out_side <= in_side;
    end
  end

endmodule

FILE: hdl/rcta_front.sv
module rcta_front import rcta_pkg::*; #(
  parameter int SCREEN_ROWS = 512,
  parameter int TEX_COLS    = 64,
  parameter int TEX_ROWS    = 64,
  parameter int WN_W        = 35,
  parameter int WD_W        = 24,
  parameter int FN_W        = 42,
  parameter int FD_W        = 34
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  pixel_t          pix,
  output logic            out_valid,
  output logic [WN_W-1:0] wrem,
  output logic [WD_W-1:0] wden,
  output logic [FN_W-1:0] frem,
  output logic [FD_W-1:0] fden,
  output side_t           side
);

  localparam int WCW = WD_W + Q_BITS + 1;
  localparam int FCW = FD_W + Q_BITS + 1;

  logic signed [25:0] d;
  logic signed [13:0] den;
  logic               den_pos, one_a;
  logic [15:0]        h;
  logic [10:0]        tcol_x;
  side_t              side_a;
  side_t              side_b;
  logic               valid_a;
  logic [WN_W-1:0]    wrem_a;
  logic [WD_W-1:0]    wden_a;
  logic [FD_W-1:0]    fden_a;

  always_comb begin
    d       = $signed({9'b0, pix.row, 8'b0}) + $signed({3'b0, pix.slice_height, 7'b0})
              - $signed(26'(SCREEN_ROWS * 128));
    den     = $signed({4'b0, pix.row, 1'b0}) - $signed(14'(SCREEN_ROWS));
    den_pos = !den[13] && (den != 14'sd0);
    one_a   = !(den_pos && (pix.wall_distance != 24'd0));
    h       = (pix.slice_height == 16'd0) ? 16'd1 : pix.slice_height;
    tcol_x  = (11'(pix.wall_texel_col) > 11'(TEX_COLS - 1)) ? 11'(TEX_COLS - 1)
              : 11'(pix.wall_texel_col);
  end

  always_comb begin
    side_b           = side_a;
    side_b.wall_sat  = (WCW'(wrem_a) >= (WCW'(wden_a) << Q_BITS));
    side_b.floor_one = side_a.floor_one
                       || ((FCW'(FN_W'(SCREEN_ROWS)) << 32) >= (FCW'(fden_a) << Q_BITS));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      valid_a   <= in_valid;
      out_valid <= valid_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (pix.row < pix.span_start) begin
        side_a.surface <= SURF_SKY;
      end else if (10'(pix.row) < pix.span_end) begin
        side_a.surface <= SURF_WALL;
      end else begin
        side_a.surface <= SURF_FLOOR;
      end
      side_a.wall_u      <= tcol_x[5:0];
      side_a.wall_neg    <= d[25];
      side_a.wall_sat    <= 1'b0;
      side_a.floor_one   <= one_a;
      side_a.floor_hit_x <= pix.floor_hit_x;
      side_a.floor_hit_y <= pix.floor_hit_y;
      side_a.viewer_x    <= pix.viewer_x;
      side_a.viewer_y    <= pix.viewer_y;
      wrem_a <= WN_W'(d[23:0]) * WN_W'(TEX_ROWS);
      wden_a <= WD_W'({h, 8'b0});
      fden_a <= one_a ? FD_W'(1) : FD_W'(den[9:0]) * FD_W'(pix.wall_distance);

      side <= side_b;
      wrem <= wrem_a;
      wden <= wden_a;
      frem <= FN_W'(SCREEN_ROWS) << 32;
      fden <= fden_a;
    end
  end

endmodule

FILE: hdl/rcta_back.sv
module rcta_back import rcta_pkg::*; #(
  parameter int TEX_COLS = 64,
  parameter int TEX_ROWS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [Q_BITS-1:0] wq,
  input  logic [Q_BITS-1:0] fq,
  input  side_t             side,
  output logic              out_valid,
  output surface_t          surface,
  output logic [5:0]        texel_u,
  output logic [5:0]        texel_v
);

  logic [Q_BITS-1:0] w, wn, v_wall;
  logic              v1, v2;
  surface_t          surf1, surf2;
  logic [5:0]        wu1, wv1, wu2, wv2;
  logic [40:0]       px_h, px_v, py_h, py_v;
  logic [31:0]       lo_x, lo_y;
  logic [40:0]       acc_x, acc_y;
  logic [42:0]       tx, ty;

  always_comb begin
    if (side.floor_one || (fq > WEIGHT_ONE)) begin
      w = WEIGHT_ONE;
    end else begin
      w = fq;
    end
    wn = WEIGHT_ONE - w;
    if (side.wall_neg) begin
      v_wall = '0;
    end else if (side.wall_sat || (wq > Q_BITS'(TEX_ROWS - 1))) begin
      v_wall = Q_BITS'(TEX_ROWS - 1);
    end else begin
      v_wall = wq;
    end
    acc_x = px_h + px_v;
    acc_y = py_h + py_v;
    tx    = 43'(lo_x) * 43'(TEX_COLS);
    ty    = 43'(lo_y) * 43'(TEX_ROWS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      surf1 <= side.surface;
      wu1   <= side.wall_u;
      wv1   <= v_wall[5:0];
      px_h  <= 41'(w) * 41'(side.floor_hit_x);
      px_v  <= 41'(wn) * 41'(side.viewer_x);
      py_h  <= 41'(w) * 41'(side.floor_hit_y);
      py_v  <= 41'(wn) * 41'(side.viewer_y);

      surf2 <= surf1;
      wu2   <= wu1;
      wv2   <= wv1;
      lo_x  <= acc_x[31:0];
      lo_y  <= acc_y[31:0];

      surface <= surf2;
      unique case (surf2)
        SURF_WALL: begin
          texel_u <= wu2;
          texel_v <= wv2;
        end
        SURF_FLOOR: begin
          texel_u <= tx[37:32];
          texel_v <= ty[37:32];
        end
        default: begin
          texel_u <= '0;
          texel_v <= '0;
        end
      endcase
    end
  end

endmodule

FILE: hdl/raycast_column_texel_address.sv
// Texel addressing for a raycast column, one screen pixel per beat.
// The slave channel carries one pixel row with its column's wall span, slice
// height, wall texture column, wall distance, floor hit point and viewer
// position. The master channel returns the surface kind on tuser and the
// texel column and row on tdata.
// A new beat is accepted on every clock while the output is free or taken,
// so the sustained rate is one pixel per cycle. The pipe is made of two
// front stages that classify the pixel and form the dividends and divisors,
// a row of 17 divider cells that each settle one quotient bit of the wall
// row division and of the floor weight division, and three back stages for
// the floor interpolation and the output register.
// The whole pipe advances together; when the receiver stalls with a result
// waiting, tready drops and every stage holds its contents.
// Reset empties the pipe and clears the output valid; no clearing pass is
// needed, and the block takes beats in the cycle after reset is released.
module raycast_column_texel_address import rcta_pkg::*; #(
  parameter int SCREEN_ROWS = 512,
  parameter int TEX_COLS    = 64,
  parameter int TEX_ROWS    = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // row, span_start, span_end, slice_height, wall_texel_col, wall_distance,
  // floor_hit_x, floor_hit_y, viewer_x, viewer_y, zero fill
  input  logic [175:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // texel_u, texel_v, zero fill
  output logic [15:0]  m_tdata,
  // surface
  output logic [1:0]   m_tuser
);

  localparam int WN_W = 24 + $clog2(TEX_ROWS + 1);
  localparam int WD_W = 24;
  localparam int FN_W = $clog2(SCREEN_ROWS + 1) + 32;
  localparam int FD_W = 34;
  localparam int SIDE_W = $bits(side_t);

  logic              en;
  pixel_t            pix;
  logic              cv   [0:Q_BITS];
  logic [WN_W-1:0]   cwr  [0:Q_BITS];
  logic [WD_W-1:0]   cwd  [0:Q_BITS];
  logic [Q_BITS-1:0] cwq  [0:Q_BITS];
  logic [FN_W-1:0]   cfr  [0:Q_BITS];
  logic [FD_W-1:0]   cfd  [0:Q_BITS];
  logic [Q_BITS-1:0] cfq  [0:Q_BITS];
  logic [SIDE_W-1:0] cs   [0:Q_BITS];
  side_t             side0, side_end;
  surface_t          surf;
  logic [5:0]        tu, tv;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign pix      = s_tdata[169:0];
  assign cs[0]    = side0;
  assign cwq[0]   = '0;
  assign cfq[0]   = '0;
  assign side_end = cs[Q_BITS];

  rcta_front #(
    .SCREEN_ROWS(SCREEN_ROWS), .TEX_COLS(TEX_COLS), .TEX_ROWS(TEX_ROWS),
    .WN_W(WN_W), .WD_W(WD_W), .FN_W(FN_W), .FD_W(FD_W)
  ) u_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(s_tvalid), .pix(pix),
    .out_valid(cv[0]), .wrem(cwr[0]), .wden(cwd[0]), .frem(cfr[0]),
    .fden(cfd[0]), .side(side0)
  );

  for (genvar i = 0; i < Q_BITS; i++) begin : g_cell
    rcta_cell #(
      .WN_W(WN_W), .WD_W(WD_W), .FN_W(FN_W), .FD_W(FD_W),
      .SHIFT(Q_BITS - 1 - i), .Q_W(Q_BITS), .SIDE_W(SIDE_W)
    ) u_cell (
      .clk(clk), .rst(rst), .en(en), .in_valid(cv[i]),
      .in_wrem(cwr[i]), .in_wden(cwd[i]), .in_wq(cwq[i]),
      .in_frem(cfr[i]), .in_fden(cfd[i]), .in_fq(cfq[i]), .in_side(cs[i]),
      .out_valid(cv[i+1]), .out_wrem(cwr[i+1]), .out_wden(cwd[i+1]),
      .out_wq(cwq[i+1]), .out_frem(cfr[i+1]), .out_fden(cfd[i+1]),
      .out_fq(cfq[i+1]), .out_side(cs[i+1])
    );
  end

  rcta_back #(.TEX_COLS(TEX_COLS), .TEX_ROWS(TEX_ROWS)) u_back (
    .clk(clk), .rst(rst), .en(en), .in_valid(cv[Q_BITS]),
    .wq(cwq[Q_BITS]), .fq(cfq[Q_BITS]), .side(side_end),
    .out_valid(m_tvalid), .surface(surf), .texel_u(tu), .texel_v(tv)
  );

  assign m_tuser = surf;
  assign m_tdata = {4'b0, tv, tu};

endmodule

FILE: hdl/rcta_checker.sv
module rcta_checker import rcta_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [1:0]  m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == SURF_SKY || m_tuser == SURF_WALL || m_tuser == SURF_FLOOR))
    else $error("undefined surface kind");

  a_sky_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == SURF_SKY |-> m_tdata == 16'd0)
    else $error("sky pixel with nonzero texel");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

endmodule

bind raycast_column_texel_address rcta_checker u_rcta_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
